>>> sv/cqf_pkg.sv
// Shared types, command codes and defaults for the filtering circular queue.
package cqf_pkg;

  localparam int DEPTH_DEF      = 8;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int CMD_W          = 3;
  localparam int TALLY_W        = 3;

  localparam logic [CMD_W-1:0] CMD_ENQ    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_EVENS  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DOUBLE = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  // datapath commands from the controller
  typedef struct packed {
    logic load;       // capture input beat, reset walk counters
    logic walk_rd;    // read front entry into the datapath
    logic walk_step;  // act on the read entry
    logic div_start;  // start remainder unit
    logic finish;     // build the final result of a single-result command
  } cqf_ctl_t;

  // datapath status to the controller
  typedef struct packed {
    logic walk_done;  // no entries left to visit
    logic div_done;   // remainder unit done
    logic emit_even;  // current step emits an extracted entry
    logic evens_none; // extract finished with nothing emitted
  } cqf_sts_t;

endpackage

>>> sv/cqf_rem.sv
// Restoring remainder unit, one quotient bit per cycle.
module cqf_rem #(
  parameter int W = cqf_pkg::DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic         zero_rem
);
  import cqf_pkg::*;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    sub;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[W-1:0], quo_r[W-1]};
    sub      = trial - {1'b0, dvs_r};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[W-2:0], 1'b0};
      rem_nxt = sub[W] ? trial : sub;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign zero_rem = (rem_r == '0);
endmodule

>>> sv/cqf_dp.sv
// Datapath: ring storage, pointers, walk counters and result fields.
module cqf_dp #(
  parameter int DEPTH      = cqf_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cqf_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cqf_pkg::cqf_ctl_t             ctl,
  output cqf_pkg::cqf_sts_t             sts,
  input  logic [cqf_pkg::CMD_W-1:0]     in_cmd,
  input  logic signed [DATA_WIDTH-1:0]  in_data_in,
  output logic signed [DATA_WIDTH-1:0]  res_data,
  output logic [cqf_pkg::TALLY_W-1:0]   res_tally,
  output logic                          res_ok
);
  import cqf_pkg::*;
  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH);
  localparam int NWD = (NW > 0) ? NW : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [NWD-1:0] left_r, left_nxt;
  logic [NWD-1:0] hits_r, hits_nxt;
  logic [CMD_W-1:0] cmd_r;
  logic [DATA_WIDTH-1:0] arg_r, div_r;
  logic [DATA_WIDTH-1:0] ent_r;
  logic           found_r, found_nxt;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] ent_mag;
  logic           div_done, zero_rem;
  logic           empty, full;
  logic [NWD-1:0] count;
  logic [DATA_WIDTH-1:0] dout_r, dout_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic           ok_r, ok_nxt;
  logic           keep;
  logic [DATA_WIDTH-1:0] keep_val;
  logic           hit;

  function automatic logic [AW-1:0] wnext(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] v);
    return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  assign empty = (wnext(tail_r) == head_r);
  assign full  = (wnext(wnext(tail_r)) == head_r);
  assign count = NWD'((AW+1)'(tail_r) + (AW+1)'(1) + (AW+1)'(DEPTH) - (AW+1)'(head_r)
                      - (((AW+1)'(tail_r) + (AW+1)'(1) + (AW+1)'(DEPTH) - (AW+1)'(head_r))
                         >= (AW+1)'(DEPTH) ? (AW+1)'(DEPTH) : '0));
  assign ent_mag = mag(ent_r);

  cqf_rem #(.W(DATA_WIDTH)) u_rem (
    .clk(clk), .rst_n(rst_n), .start(ctl.div_start),
    .dividend(ent_mag), .divisor(div_r),
    .done(div_done), .zero_rem(zero_rem)
  );

  always_comb begin
    hit      = 1'b0;
    keep     = 1'b1;
    keep_val = ent_r;
    unique case (cmd_r)
      CMD_REMOVE: begin
        hit  = !found_r && (ent_r == arg_r);
        keep = !hit;
      end
      CMD_EVENS: begin
        hit  = !ent_r[0];
        keep = !hit;
      end
      CMD_DOUBLE: begin
        hit = (div_r != '0) && zero_rem;
        if (hit) begin
          keep_val = {ent_r[DATA_WIDTH-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    left_nxt  = left_r;
    hits_nxt  = hits_r;
    found_nxt = found_r;
    dout_nxt  = dout_r;
    tally_nxt = tally_r;
    ok_nxt    = ok_r;
    wr_en     = 1'b0;
    wr_addr   = wnext(tail_r);
    wr_data   = arg_r;
    if (ctl.load) begin
      left_nxt  = count;
      hits_nxt  = '0;
      found_nxt = 1'b0;
    end else if (ctl.walk_step) begin
      head_nxt = wnext(head_r);
      left_nxt = left_r - 1'b1;
      if (hit) begin
        hits_nxt  = hits_r + 1'b1;
        found_nxt = 1'b1;
      end
      if (keep) begin
        wr_en    = 1'b1;
        wr_addr  = wnext(tail_r);
        wr_data  = keep_val;
        tail_nxt = wnext(tail_r);
      end
      if (cmd_r == CMD_EVENS && hit) begin
        dout_nxt  = ent_r;
        tally_nxt = TALLY_W'(hits_r + 1'b1);
        ok_nxt    = 1'b1;
      end
    end else if (ctl.finish) begin
      dout_nxt  = '0;
      ok_nxt    = 1'b0;
      tally_nxt = '0;
      unique case (cmd_r)
        CMD_ENQ: begin
          ok_nxt = !full;
          if (!full) begin
            wr_en    = 1'b1;
            tail_nxt = wnext(tail_r);
          end
          tally_nxt = TALLY_W'(count + (full ? 1'b0 : 1'b1));
        end
        CMD_DEQ: begin
          ok_nxt = !empty;
          if (!empty) begin
            head_nxt  = wnext(head_r);
            tally_nxt = TALLY_W'(count - 1'b1);
          end else begin
            tally_nxt = TALLY_W'(count);
          end
        end
        CMD_PEEK: begin
          ok_nxt    = !empty;
          dout_nxt  = empty ? '0 : ent_r;
          tally_nxt = TALLY_W'(count);
        end
        CMD_COUNT: begin
          ok_nxt    = 1'b1;
          tally_nxt = TALLY_W'(count);
        end
        CMD_REMOVE: begin
          ok_nxt    = found_r;
          tally_nxt = TALLY_W'(count);
        end
        CMD_EVENS: ;
        CMD_DOUBLE: begin
          ok_nxt    = (hits_r != '0);
          tally_nxt = TALLY_W'(hits_r);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.walk_rd) begin
      ent_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      arg_r <= in_data_in;
      div_r <= mag(in_data_in);
    end
    left_r  <= left_nxt;
    hits_r  <= hits_nxt;
    found_r <= found_nxt;
    dout_r  <= dout_nxt;
    tally_r <= tally_nxt;
    ok_r    <= ok_nxt;
    if (!rst_n) begin
      head_r <= LAST_IDX;
      tail_r <= AW'(DEPTH - 2);
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  assign sts.walk_done  = (left_r == '0);
  assign sts.div_done   = div_done;
  assign sts.emit_even  = (cmd_r == CMD_EVENS) && hit;
  assign sts.evens_none = (hits_r == '0);
  assign res_data  = dout_r;
  assign res_tally = tally_r;
  assign res_ok    = ok_r;
endmodule

>>> sv/cqf_ctrl.sv
// Controller: sequences command walks and drives the result handshake.
module cqf_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cqf_pkg::CMD_W-1:0] in_cmd,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_last,
  output cqf_pkg::cqf_ctl_t         ctl,
  input  cqf_pkg::cqf_sts_t         sts
);
  import cqf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r;
  logic last_r, last_nxt;
  logic walk_cmd;
  logic held_r, held_nxt; // extracted beat waiting in the result registers

  assign walk_cmd = (in_cmd == CMD_REMOVE) || (in_cmd == CMD_EVENS) || (in_cmd == CMD_DOUBLE);
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_last  = last_r;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    held_nxt  = held_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          ctl.walk_rd = 1'b1;
          state_nxt = walk_cmd ? S_RD : S_FIN;
        end
      end
      S_RD: begin
        ctl.walk_rd = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_FIN;
        end else if (cmd_r == CMD_DOUBLE) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_DIV: begin
        ctl.div_start = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (cmd_r == CMD_DOUBLE && !sts.div_done) begin
          state_nxt = S_CHK;
        end else if (sts.emit_even && held_r) begin
          // another even found: the held beat is not the last one
          last_nxt  = 1'b0;
          state_nxt = S_OUT;
        end else begin
          ctl.walk_step = 1'b1;
          if (sts.emit_even) begin
            held_nxt = 1'b1;
          end
          state_nxt = S_RD;
        end
      end
      S_FIN: begin
        if (cmd_r == CMD_EVENS && !sts.evens_none) begin
          // held beat is the final extracted entry
          last_nxt  = 1'b1;
          held_nxt  = 1'b0;
          state_nxt = S_OUT;
        end else begin
          ctl.finish = 1'b1;
          last_nxt   = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            held_nxt  = 1'b0;
            state_nxt = S_CHK;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_cmd;
    end
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
      held_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      held_r  <= held_nxt;
    end
  end
endmodule

>>> sv/circular_queue_with_filter_ops.sv
// Top level: filtering circular queue, controller plus datapath.
//   channel  signals                              role
//   in       in_valid/in_ready, in_cmd, in_data_in command beat
//   out      out_valid/out_ready, out_data_out,    result beat(s)
//            out_tally, out_ok, out_last
// Simple commands go from idle through the finish state to the out handshake.
// Filter commands walk every held entry through a shared memory read port,
// reading and then acting on each entry, and double multiples also tests
// it in the bit-serial remainder unit. Extract evens must look ahead to flag
// the last beat, so its emitted beats are held until the next even or walk end.
// Synchronous active-low reset; no clearing pass; stalls on out hold the walk.
module circular_queue_with_filter_ops #(
  parameter int DEPTH      = cqf_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cqf_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cqf_pkg::CMD_W-1:0]     in_cmd,
  input  logic signed [DATA_WIDTH-1:0]  in_data_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]  out_data_out,
  output logic [cqf_pkg::TALLY_W-1:0]   out_tally,
  output logic                          out_ok,
  output logic                          out_last
);
  import cqf_pkg::*;

  cqf_ctl_t ctl;
  cqf_sts_t sts;
  logic signed [DATA_WIDTH-1:0] res_data;
  logic [TALLY_W-1:0] res_tally;
  logic res_ok;

  cqf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .out_valid(out_valid), .out_ready(out_ready), .out_last(out_last),
    .ctl(ctl), .sts(sts)
  );

  cqf_dp #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_cmd(in_cmd), .in_data_in(in_data_in),
    .res_data(res_data), .res_tally(res_tally), .res_ok(res_ok)
  );

  assign out_data_out = res_data;
  assign out_tally    = res_tally;
  assign out_ok       = res_ok;
endmodule

>>> test/cqf_checker.sv
// Checker for the filtering circular queue: queue predictor and result compare.
module cqf_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [cqf_pkg::CMD_W-1:0] in_cmd,
  input  logic signed [31:0]        in_data_in,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [31:0]        out_data_out,
  input  logic [2:0]                out_tally,
  input  logic                      out_ok,
  input  logic                      out_last,
  output int                        fail_count,
  output int                        pending
);
  import cqf_pkg::*;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  tally;
    logic        ok;
    logic        last;
  } result_t;

  logic [31:0] held[$];
  result_t     expected_q[$];

  function automatic logic [31:0] mag(logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic void push_result(logic [31:0] d, int t, logic ok, logic last);
    result_t r;
    r.data = d;
    r.tally = t[2:0];
    r.ok = ok;
    r.last = last;
    expected_q.push_back(r);
  endfunction

  task automatic apply_command(logic [2:0] cmd, logic [31:0] arg);
    logic [31:0] kept[$];
    logic        found;
    int          hits;
    logic [31:0] dv;
    found = 0;
    hits = 0;
    case (cmd)
      CMD_ENQ: begin
        found = held.size() < 7;
        if (found) held.push_back(arg);
        push_result(0, held.size(), found, 1);
      end
      CMD_DEQ: begin
        found = held.size() > 0;
        if (found) void'(held.pop_front());
        push_result(0, held.size(), found, 1);
      end
      CMD_PEEK: begin
        if (held.size() > 0) push_result(held[0], held.size(), 1, 1);
        else push_result(0, 0, 0, 1);
      end
      CMD_COUNT: push_result(0, held.size(), 1, 1);
      CMD_REMOVE: begin
        foreach (held[i]) begin
          if (!found && held[i] == arg) found = 1;
          else kept.push_back(held[i]);
        end
        held = kept;
        push_result(0, held.size(), found, 1);
      end
      CMD_EVENS: begin
        foreach (held[i]) begin
          if (!held[i][0]) begin
            hits++;
            push_result(held[i], hits, 1, 0);
          end else kept.push_back(held[i]);
        end
        held = kept;
        if (hits == 0) push_result(0, 0, 0, 1);
        else expected_q[$].last = 1;
      end
      CMD_DOUBLE: begin
        dv = mag(arg);
        foreach (held[i]) begin
          if (dv != 0 && mag(held[i]) % dv == 0) begin
            held[i] = held[i] << 1;
            hits++;
          end
        end
        push_result(0, hits, hits != 0, 1);
      end
      default: push_result(0, 0, 0, 1);
    endcase
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    result_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      held.delete();
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) apply_command(in_cmd, in_data_in);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result beat");
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (out_data_out !== e.data) begin
            $error("data_out exp %0d got %0d", $signed(e.data), out_data_out);
            errs++;
          end
          if (out_tally !== e.tally) begin
            $error("tally exp %0d got %0d", e.tally, out_tally);
            errs++;
          end
          if (out_ok !== e.ok) begin
            $error("ok exp %0d got %0d", e.ok, out_ok);
            errs++;
          end
          if (out_last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_last);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

>>> test/tb_circular_queue_with_filter_ops.sv
// Testbench top: stimulus, receiver stalls and verdict for the filtering queue.
module tb_circular_queue_with_filter_ops;
  import cqf_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [CMD_W-1:0]  in_cmd;
  logic signed [31:0] in_data_in;
  logic              out_valid;
  logic              out_ready;
  logic signed [31:0] out_data_out;
  logic [2:0]        out_tally;
  logic              out_ok;
  logic              out_last;
  int                fail_count;
  int                pending;
  int                cycle_count;
  logic              hold_off;

  circular_queue_with_filter_ops uut (.*);

  cqf_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver: random stall pattern, one long hold-off
  initial begin
    int mode;
    out_ready = 0;
    hold_off = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) out_ready <= 0;
      else begin
        mode = (cycle_count / 300) % 3;
        if (mode == 0) out_ready <= 1;
        else if (mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
        else out_ready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  task automatic send(logic [2:0] cmd, logic [31:0] d);
    in_cmd <= cmd;
    in_data_in <= d;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic gap();
    in_valid <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 20);
      3: return -$urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] rand_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CMD_ENQ;
    if (r < 45) return CMD_DEQ;
    if (r < 55) return CMD_PEEK;
    if (r < 62) return CMD_COUNT;
    if (r < 74) return CMD_REMOVE;
    if (r < 84) return CMD_EVENS;
    if (r < 97) return CMD_DOUBLE;
    return CMD_UNUSED;
  endfunction

  initial begin
    int burst;
    logic [2:0] c;
    logic [31:0] d;
    rst_n = 0;
    in_valid = 0;
    in_cmd = CMD_COUNT;
    in_data_in = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: empty cases, fill to full, special values
    send(CMD_DEQ, 0);
    send(CMD_PEEK, 0);
    send(CMD_EVENS, 0);
    send(CMD_REMOVE, 5);
    send(CMD_ENQ, 32'h8000_0000);
    send(CMD_ENQ, 32'h7fff_ffff);
    send(CMD_ENQ, -6);
    send(CMD_ENQ, 0);
    send(CMD_ENQ, 9);
    send(CMD_ENQ, 12);
    send(CMD_ENQ, 32'hffff_ffff);
    send(CMD_ENQ, 4);
    send(CMD_COUNT, 0);
    send(CMD_PEEK, 0);
    send(CMD_DOUBLE, 0);
    send(CMD_DOUBLE, -1);
    send(CMD_DOUBLE, 3);
    send(CMD_REMOVE, 32'h7fff_ffff);
    send(CMD_REMOVE, 77);
    send(CMD_UNUSED, 32'h5555_aaaa);
    send(CMD_EVENS, 0);
    send(CMD_DEQ, 0);
    send(CMD_COUNT, 0);
    in_valid <= 0;

    // long receiver hold-off while items keep coming
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      repeat (12) send(CMD_ENQ, $urandom_range(0, 30));
    join
    in_valid <= 0;

    for (int n = 0; n < 175; ) begin
      burst = $urandom_range(1, 10);
      for (int b = 0; b < burst && n < 175; b++, n++) begin
        c = rand_cmd();
        d = rand_word();
        send(c, d);
      end
      if ($urandom_range(0, 2) != 0) gap();
    end
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
